[rtl/core/gbp_pkg.sv]
// Shared types, byte codes and helpers for the GIF block parser.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package gbp_pkg;

  // Byte roles reported with every beat.
  localparam logic [3:0] ROLE_SIG      = 4'd0;
  localparam logic [3:0] ROLE_VER      = 4'd1;
  localparam logic [3:0] ROLE_SCREEN   = 4'd2;
  localparam logic [3:0] ROLE_GCT      = 4'd3;
  localparam logic [3:0] ROLE_EXT_INTRO = 4'd4;
  localparam logic [3:0] ROLE_EXT_LABEL = 4'd5;
  localparam logic [3:0] ROLE_SUB_LEN  = 4'd6;
  localparam logic [3:0] ROLE_SUB_DATA = 4'd7;
  localparam logic [3:0] ROLE_IMG_SEP  = 4'd8;
  localparam logic [3:0] ROLE_IMG_DESC = 4'd9;
  localparam logic [3:0] ROLE_LCT      = 4'd10;
  localparam logic [3:0] ROLE_IMG_DATA = 4'd11;
  localparam logic [3:0] ROLE_IGNORED  = 4'd12;

  // Field identifiers.
  localparam logic [3:0] FLD_NONE       = 4'd0;
  localparam logic [3:0] FLD_VERSION    = 4'd1;
  localparam logic [3:0] FLD_SCR_WIDTH  = 4'd2;
  localparam logic [3:0] FLD_SCR_HEIGHT = 4'd3;
  localparam logic [3:0] FLD_SCR_PACKED = 4'd4;
  localparam logic [3:0] FLD_BACKGROUND = 4'd5;
  localparam logic [3:0] FLD_ASPECT     = 4'd6;
  localparam logic [3:0] FLD_GCE_PACKED = 4'd7;
  localparam logic [3:0] FLD_DELAY      = 4'd8;
  localparam logic [3:0] FLD_TRANSP     = 4'd9;
  localparam logic [3:0] FLD_IMG_LEFT   = 4'd10;
  localparam logic [3:0] FLD_IMG_PACKED = 4'd14;
  localparam logic [3:0] FLD_COMMENT_LEN = 4'd15;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_SIG     = 2'd1;
  localparam logic [1:0] ERR_VERSION = 2'd2;
  localparam logic [1:0] ERR_NO_SEP  = 2'd3;

  // Byte values of the file format.
  localparam logic [7:0] CH_G         = 8'h47;
  localparam logic [7:0] CH_I         = 8'h49;
  localparam logic [7:0] CH_F         = 8'h46;
  localparam logic [7:0] CH_8         = 8'h38;
  localparam logic [7:0] CH_7         = 8'h37;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] BYTE_EXT     = 8'h21;
  localparam logic [7:0] BYTE_IMG_SEP = 8'h2c;
  localparam logic [7:0] LABEL_GCE    = 8'hf9;
  localparam logic [7:0] LABEL_COMMENT = 8'hfe;

  localparam logic [15:0] VERSION_87 = 16'd87;
  localparam logic [15:0] VERSION_89 = 16'd89;

  // One result beat.
  typedef struct packed {
    logic [3:0]  byte_role;
    logic [3:0]  field_id;
    logic [15:0] field_value;
    logic        field_valid;
    logic [7:0]  palette_index;
    logic [1:0]  palette_component;
    logic        version_is_89;
    logic        interlaced;
    logic [1:0]  error_code;
    logic        image_data_reached;
  } gbp_result_t;

  // Color table length in bytes from a packed flags byte.
  function automatic logic [9:0] table_size(input logic [7:0] packed_flags);
    logic [3:0] shamt;
    shamt = {1'b0, packed_flags[2:0]} + 4'd1;
    if (packed_flags[7]) begin
      table_size = 10'd3 << shamt;
    end else begin
      table_size = 10'd0;
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/gbp_step.sv]
// Parser state registers and the combinational next-state and result logic.
// Depends on gbp_pkg for codes, the result type and the table size helper.
`default_nettype none

module gbp_step
  import gbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_of_file,
  output gbp_result_t      result
);

  typedef enum logic [3:0] {
    PH_SIG, PH_VER, PH_SCREEN, PH_GCT, PH_BLOCK, PH_LABEL, PH_SUBLEN,
    PH_SUBDATA, PH_IMGDESC, PH_LCT, PH_IMGDATA, PH_ERR
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_cur;
  logic [9:0]  bip_r, bip_nxt, bip_cur;
  logic [9:0]  tbl_left_r, tbl_left_nxt, tbl_left_cur;
  logic [7:0]  low_r, low_nxt, low_cur;
  logic        ver_r, ver_nxt, ver_cur;
  logic [7:0]  sub_left_r, sub_left_nxt, sub_left_cur;
  logic [7:0]  ext_kind_r, ext_kind_nxt, ext_kind_cur;
  logic        first_sb_r, first_sb_nxt, first_sb_cur;
  logic        ilace_r, ilace_nxt, ilace_cur;
  logic [1:0]  err_r, err_nxt, err_cur;
  logic [7:0]  pal_idx_r, pal_idx_nxt, pal_idx_cur;
  logic [1:0]  pal_comp_r, pal_comp_nxt, pal_comp_cur;

  // A start-of-file beat sees the reset state.
  assign phase_cur    = start_of_file ? PH_SIG : phase_r;
  assign bip_cur      = start_of_file ? 10'd0 : bip_r;
  assign tbl_left_cur = start_of_file ? 10'd0 : tbl_left_r;
  assign low_cur      = start_of_file ? 8'd0 : low_r;
  assign ver_cur      = start_of_file ? 1'b0 : ver_r;
  assign sub_left_cur = start_of_file ? 8'd0 : sub_left_r;
  assign ext_kind_cur = start_of_file ? 8'd0 : ext_kind_r;
  assign first_sb_cur = start_of_file ? 1'b0 : first_sb_r;
  assign ilace_cur    = start_of_file ? 1'b0 : ilace_r;
  assign err_cur      = start_of_file ? ERR_NONE : err_r;
  assign pal_idx_cur  = start_of_file ? 8'd0 : pal_idx_r;
  assign pal_comp_cur = start_of_file ? 2'd0 : pal_comp_r;

  // One parser step for the incoming byte.
  always_comb begin
    logic [3:0]  role;
    logic [3:0]  fid;
    logic [15:0] fval;
    logic        fvalid;
    logic [7:0]  pidx;
    logic [1:0]  pcomp;
    logic        gce_capture;

    phase_nxt    = phase_cur;
    bip_nxt      = bip_cur;
    tbl_left_nxt = tbl_left_cur;
    low_nxt      = low_cur;
    ver_nxt      = ver_cur;
    sub_left_nxt = sub_left_cur;
    ext_kind_nxt = ext_kind_cur;
    first_sb_nxt = first_sb_cur;
    ilace_nxt    = ilace_cur;
    err_nxt      = err_cur;
    pal_idx_nxt  = pal_idx_cur;
    pal_comp_nxt = pal_comp_cur;
    role   = ROLE_IGNORED;
    fid    = FLD_NONE;
    fval   = 16'd0;
    fvalid = 1'b0;
    pidx   = 8'd0;
    pcomp  = 2'd0;
    gce_capture = first_sb_cur && (ext_kind_cur == LABEL_GCE) && ver_cur;

    unique case (phase_cur)
      PH_SIG: begin
        role = ROLE_SIG;
        if ((bip_cur == 10'd0 && data_byte == CH_G) ||
            (bip_cur == 10'd1 && data_byte == CH_I)) begin
          bip_nxt = bip_cur + 10'd1;
        end else if (bip_cur == 10'd2 && data_byte == CH_F) begin
          bip_nxt   = 10'd0;
          phase_nxt = PH_VER;
        end else begin
          err_nxt   = ERR_SIG;
          phase_nxt = PH_ERR;
        end
      end
      PH_VER: begin
        role = ROLE_VER;
        if (bip_cur == 10'd0) begin
          if (data_byte != CH_8) begin
            err_nxt   = ERR_VERSION;
            phase_nxt = PH_ERR;
          end else begin
            bip_nxt = 10'd1;
          end
        end else if (bip_cur == 10'd1) begin
          if (data_byte != CH_7 && data_byte != CH_9) begin
            err_nxt   = ERR_VERSION;
            phase_nxt = PH_ERR;
          end else begin
            low_nxt = data_byte;
            bip_nxt = 10'd2;
          end
        end else begin
          if (data_byte != CH_A) begin
            err_nxt   = ERR_VERSION;
            phase_nxt = PH_ERR;
          end else begin
            ver_nxt   = (low_cur == CH_9);
            fid       = FLD_VERSION;
            fval      = (low_cur == CH_9) ? VERSION_89 : VERSION_87;
            fvalid    = 1'b1;
            bip_nxt   = 10'd0;
            phase_nxt = PH_SCREEN;
          end
        end
      end
      PH_SCREEN: begin
        role    = ROLE_SCREEN;
        bip_nxt = bip_cur + 10'd1;
        case (bip_cur)
          10'd0, 10'd2: begin
            low_nxt = data_byte;
          end
          10'd1: begin
            fid = FLD_SCR_WIDTH; fval = {data_byte, low_cur}; fvalid = 1'b1;
          end
          10'd3: begin
            fid = FLD_SCR_HEIGHT; fval = {data_byte, low_cur}; fvalid = 1'b1;
          end
          10'd4: begin
            fid = FLD_SCR_PACKED; fval = {8'd0, data_byte}; fvalid = 1'b1;
            tbl_left_nxt = table_size(data_byte);
          end
          10'd5: begin
            fid = FLD_BACKGROUND; fval = {8'd0, data_byte}; fvalid = 1'b1;
          end
          default: begin
            fid = FLD_ASPECT; fval = {8'd0, data_byte}; fvalid = 1'b1;
            bip_nxt      = 10'd0;
            pal_idx_nxt  = 8'd0;
            pal_comp_nxt = 2'd0;
            phase_nxt    = (tbl_left_cur != 10'd0) ? PH_GCT : PH_BLOCK;
          end
        endcase
      end
      PH_GCT, PH_LCT: begin
        role  = (phase_cur == PH_GCT) ? ROLE_GCT : ROLE_LCT;
        pidx  = pal_idx_cur;
        pcomp = pal_comp_cur;
        // Entry and component counters stand in for the byte count / 3.
        if (pal_comp_cur == 2'd2) begin
          pal_comp_nxt = 2'd0;
          pal_idx_nxt  = pal_idx_cur + 8'd1;
        end else begin
          pal_comp_nxt = pal_comp_cur + 2'd1;
        end
        if (tbl_left_cur != 10'd0) begin
          tbl_left_nxt = tbl_left_cur - 10'd1;
        end
        if (tbl_left_cur <= 10'd1) begin
          bip_nxt   = 10'd0;
          phase_nxt = (phase_cur == PH_GCT) ? PH_BLOCK : PH_IMGDATA;
        end
      end
      PH_BLOCK: begin
        if (data_byte == BYTE_EXT) begin
          role      = ROLE_EXT_INTRO;
          phase_nxt = PH_LABEL;
        end else if (data_byte == BYTE_IMG_SEP) begin
          role      = ROLE_IMG_SEP;
          bip_nxt   = 10'd0;
          phase_nxt = PH_IMGDESC;
        end else begin
          err_nxt   = ERR_NO_SEP;
          phase_nxt = PH_ERR;
        end
      end
      PH_LABEL: begin
        role         = ROLE_EXT_LABEL;
        ext_kind_nxt = data_byte;
        first_sb_nxt = 1'b1;
        phase_nxt    = PH_SUBLEN;
      end
      PH_SUBLEN: begin
        role = ROLE_SUB_LEN;
        if (first_sb_cur && ext_kind_cur == LABEL_COMMENT && ver_cur) begin
          fid = FLD_COMMENT_LEN; fval = {8'd0, data_byte}; fvalid = 1'b1;
        end
        if (data_byte == 8'd0) begin
          first_sb_nxt = 1'b0;
          phase_nxt    = PH_BLOCK;
        end else begin
          sub_left_nxt = data_byte;
          bip_nxt      = 10'd0;
          phase_nxt    = PH_SUBDATA;
        end
      end
      PH_SUBDATA: begin
        role = ROLE_SUB_DATA;
        // Graphic control fields come from the first sub-block only.
        if (gce_capture) begin
          case (bip_cur)
            10'd0: begin
              fid = FLD_GCE_PACKED; fval = {8'd0, data_byte}; fvalid = 1'b1;
            end
            10'd1: begin
              low_nxt = data_byte;
            end
            10'd2: begin
              fid = FLD_DELAY; fval = {data_byte, low_cur}; fvalid = 1'b1;
            end
            10'd3: begin
              fid = FLD_TRANSP; fval = {8'd0, data_byte}; fvalid = 1'b1;
            end
            default: begin
            end
          endcase
        end
        bip_nxt = bip_cur + 10'd1;
        if (sub_left_cur != 8'd0) begin
          sub_left_nxt = sub_left_cur - 8'd1;
        end
        if (sub_left_cur <= 8'd1) begin
          first_sb_nxt = 1'b0;
          phase_nxt    = PH_SUBLEN;
        end
      end
      PH_IMGDESC: begin
        role = ROLE_IMG_DESC;
        if (bip_cur >= 10'd8) begin
          fid = FLD_IMG_PACKED; fval = {8'd0, data_byte}; fvalid = 1'b1;
          ilace_nxt    = data_byte[6];
          tbl_left_nxt = table_size(data_byte);
          bip_nxt      = 10'd0;
          pal_idx_nxt  = 8'd0;
          pal_comp_nxt = 2'd0;
          phase_nxt    = (table_size(data_byte) != 10'd0) ? PH_LCT : PH_IMGDATA;
        end else begin
          if (!bip_cur[0]) begin
            low_nxt = data_byte;
          end else begin
            // Left, top, width and height in order of the byte pair.
            fid    = FLD_IMG_LEFT + {2'd0, bip_cur[2:1]};
            fval   = {data_byte, low_cur};
            fvalid = 1'b1;
          end
          bip_nxt = bip_cur + 10'd1;
        end
      end
      PH_IMGDATA: begin
        role = ROLE_IMG_DATA;
      end
      PH_ERR: begin
        role = ROLE_IGNORED;
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase

    result.byte_role          = role;
    result.field_id           = fid;
    result.field_value        = fval;
    result.field_valid        = fvalid;
    result.palette_index      = pidx;
    result.palette_component  = pcomp;
    result.version_is_89      = ver_nxt;
    result.interlaced         = ilace_nxt;
    result.error_code         = err_nxt;
    result.image_data_reached = (role == ROLE_IMG_DATA);
  end

  // Parser state, updated on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SIG;
      bip_r      <= 10'd0;
      tbl_left_r <= 10'd0;
      low_r      <= 8'd0;
      ver_r      <= 1'b0;
      sub_left_r <= 8'd0;
      ext_kind_r <= 8'd0;
      first_sb_r <= 1'b0;
      ilace_r    <= 1'b0;
      err_r      <= ERR_NONE;
      pal_idx_r  <= 8'd0;
      pal_comp_r <= 2'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bip_r      <= bip_nxt;
      tbl_left_r <= tbl_left_nxt;
      low_r      <= low_nxt;
      ver_r      <= ver_nxt;
      sub_left_r <= sub_left_nxt;
      ext_kind_r <= ext_kind_nxt;
      first_sb_r <= first_sb_nxt;
      ilace_r    <= ilace_nxt;
      err_r      <= err_nxt;
      pal_idx_r  <= pal_idx_nxt;
      pal_comp_r <= pal_comp_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gbp_out_buf.sv]
// Two-entry result buffer that decouples the input stall from the output stall.
// Depends on gbp_pkg for the result type.
`default_nettype none

module gbp_out_buf
  import gbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire gbp_result_t push_data,
  input  wire logic        pop,
  output logic             full,
  output logic             not_empty,
  output gbp_result_t      head
);

  gbp_result_t entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = entry_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[rtl/core/gif_block_parser.sv]
// GIF block-structure parser: one file byte in, one tagged result beat out.
// Each result beat is registered in the result buffer when its byte is accepted.
// Throughput: one byte per cycle while the buffer is not full; the parser state updates in a single step.
// A two-beat result buffer absorbs output stalls; once it is full the input
// stalls until a beat leaves. Reset: synchronous, active low; the parser
// returns to expecting a signature and the buffer empties.
`default_nettype none

module gif_block_parser
  import gbp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_byte_role,
  output logic [3:0]       out_field_id,
  output logic [15:0]      out_field_value,
  output logic             out_field_valid,
  output logic [7:0]       out_palette_index,
  output logic [1:0]       out_palette_component,
  output logic             out_version_is_89,
  output logic             out_interlaced,
  output logic [1:0]       out_error_code,
  output logic             out_image_data_reached
);

  logic        in_accept;
  logic        out_accept;
  logic        buf_full;
  gbp_result_t step_result;
  gbp_result_t head;

  assign in_stall   = buf_full;
  assign in_accept  = in_valid && !buf_full;
  assign out_accept = out_valid && !out_stall;

  // Parser state and per-byte decode.
  gbp_step u_step (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (in_accept),
    .data_byte     (in_data_byte),
    .start_of_file (in_start_of_file),
    .result        (step_result)
  );

  // Result buffer.
  gbp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (step_result),
    .pop       (out_accept),
    .full      (buf_full),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_byte_role          = head.byte_role;
  assign out_field_id           = head.field_id;
  assign out_field_value        = head.field_value;
  assign out_field_valid        = head.field_valid;
  assign out_palette_index      = head.palette_index;
  assign out_palette_component  = head.palette_component;
  assign out_version_is_89      = head.version_is_89;
  assign out_interlaced         = head.interlaced;
  assign out_error_code         = head.error_code;
  assign out_image_data_reached = head.image_data_reached;

  // A full buffer always has a beat to offer.
  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty result buffer");

  // Image data flag tracks the image data role.
  a_imgdata_role: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_image_data_reached == (out_byte_role == ROLE_IMG_DATA)))
    else $error("image data flag disagrees with byte role");

  // No field reported means a cleared field id and value.
  a_field_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_field_valid) |->
      (out_field_id == FLD_NONE && out_field_value == 16'd0))
    else $error("field payload set without field valid");

  // Palette components only appear on color table bytes.
  a_palette_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_palette_component != 2'd0) |->
      (out_byte_role == ROLE_GCT || out_byte_role == ROLE_LCT))
    else $error("palette component on a non-color byte");

  // An accepted byte with nothing in flight shows up on the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !out_valid) |=> out_valid)
    else $error("accepted byte did not reach the result buffer");

endmodule

`default_nettype wire
